[rtl/core/mabb_pkg.sv]
// Shared types for the moving average / Bollinger band block.
// No dependencies.
package mabb_pkg;

	localparam int unsigned WIN_W       = 7;
	localparam int unsigned WIN_RESET   = 20;
	localparam int unsigned MEAN_W      = 24;
	localparam int unsigned STD_W       = 23;
	localparam int unsigned BAND_W      = 25;
	localparam int unsigned IN_PRICE_W  = 24;
	localparam int unsigned REG_WINDOW  = 0;

	typedef struct packed {
		logic [MEAN_W-1:0] mean_price;
		logic [STD_W-1:0]  std_dev;
		logic [BAND_W-1:0] upper_band;
		logic [BAND_W-1:0] lower_band;
		logic              valid_res;
	} res_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_SUM   = 8'b0000_0010,
		ST_MULT  = 8'b0000_0100,
		ST_DIVM  = 8'b0000_1000,
		ST_DIVV  = 8'b0001_0000,
		ST_SQRT  = 8'b0010_0000,
		ST_OUT   = 8'b0100_0000,
		ST_LOAD  = 8'b1000_0000
	} back_state_t;

endpackage

[rtl/core/mabb_fifo.sv]
// Small register queue, used between front and back and on the result side.
// No package dependencies.
module mabb_fifo #(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/mabb_front.sv]
// Front end: window register, series bookkeeping and job classification.
// Depends on mabb_pkg.
module mabb_front import mabb_pkg::*; #(
	parameter int unsigned MAX_WINDOW = 64,
	parameter int unsigned PRICE_BITS = 24,
	localparam int unsigned PTR_W = $clog2(MAX_WINDOW),
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int unsigned JOB_W = PRICE_BITS + PTR_W + CNT_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [WIN_W-1:0]      cfg_data,
	output logic [WIN_W-1:0]      window_length,
	input  logic                  in_take,
	input  logic [IN_PRICE_W-1:0] close_price,
	input  logic                  first_of_series,
	output logic [JOB_W-1:0]      job
);
	logic [WIN_W-1:0] win_q;
	logic [PTR_W-1:0] wp_q, wp_base, wp_next;
	logic [CNT_W-1:0] seen_q, seen_base, seen_next, n_c;
	logic             ok_c;

	assign window_length = win_q;

	always_comb begin
		wp_base   = first_of_series ? '0 : wp_q;
		seen_base = first_of_series ? '0 : seen_q;
		wp_next   = (wp_base == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_base + 1'b1;
		seen_next = (seen_base == CNT_W'(MAX_WINDOW)) ? seen_base : seen_base + 1'b1;
		// zero window means one, oversize saturates
		if (win_q == '0) begin
			n_c = CNT_W'(1);
		end else if (32'(win_q) > MAX_WINDOW) begin
			n_c = CNT_W'(MAX_WINDOW);
		end else begin
			n_c = CNT_W'(win_q);
		end
		ok_c = (seen_next >= n_c);
	end

	assign job = {close_price[PRICE_BITS-1:0], wp_base, n_c, ok_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= WIN_W'(WIN_RESET);
			wp_q   <= '0;
			seen_q <= '0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_data;
			end
			if (in_take) begin
				wp_q   <= wp_next;
				seen_q <= seen_next;
			end
		end
	end

endmodule

[rtl/core/mabb_back.sv]
// Back end: price ring, window sums, shared bit-serial divider and root.
// Depends on mabb_pkg.
module mabb_back import mabb_pkg::*; #(
	parameter int unsigned MAX_WINDOW = 64,
	parameter int unsigned PRICE_BITS = 24,
	localparam int unsigned PTR_W = $clog2(MAX_WINDOW),
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1),
	localparam int unsigned JOB_W = PRICE_BITS + PTR_W + CNT_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [JOB_W-1:0] job,
	input  logic             job_empty,
	output logic             job_pop,
	output res_t             res,
	input  logic             res_full,
	output logic             res_push
);
	localparam int unsigned PB   = PRICE_BITS;
	localparam int unsigned S_W  = PB + CNT_W;
	localparam int unsigned Q_W  = 2 * PB + CNT_W;
	localparam int unsigned NQ_W = Q_W + CNT_W;
	localparam int unsigned NN_W = 2 * CNT_W;
	localparam int unsigned DV_W = NQ_W;
	localparam int unsigned V_W  = 2 * PB;
	localparam int unsigned C_W  = $clog2(DV_W + 1);

	back_state_t state_q;

	logic [PB-1:0]    hist_q [MAX_WINDOW];
	logic [PB-1:0]    j_price;
	logic [PTR_W-1:0] j_slot;
	logic [CNT_W-1:0] j_n;
	logic             j_ok;

	logic [CNT_W-1:0] n_q, iss_q, acc_q;
	logic [PTR_W-1:0] addr_q;
	logic [PB-1:0]    rdata_q, x_s2;
	logic [V_W-1:0]   sq_s2;
	logic             rv_s1, v_s2;
	logic [S_W-1:0]   s_q;
	logic [Q_W-1:0]   q_q;
	logic [NQ_W-1:0]  nq_q;
	logic [NQ_W-1:0]  ss_q;
	logic [NN_W-1:0]  nn_q;
	logic             ok_q;

	logic [DV_W-1:0]  dvd_q, quo_q;
	logic [NN_W-1:0]  dvs_q, rem_q;
	logic [C_W-1:0]   cnt_q;
	logic [NN_W:0]    dv_t;
	logic             dv_ge;

	logic [V_W-1:0]   var_q;
	logic [PB-1:0]    root_q, mean_q;
	logic [PB+1:0]    srem_q, sq_t, sq_trial;
	logic             sq_ge;

	assign {j_price, j_slot, j_n, j_ok} = job;
	assign job_pop  = (state_q == ST_IDLE) && !job_empty;
	assign res_push = (state_q == ST_OUT) && !res_full;

	always_comb begin
		dv_t     = {rem_q, dvd_q[DV_W-1]};
		dv_ge    = (dv_t >= {1'b0, dvs_q});
		sq_t     = {srem_q[PB-1:0], var_q[V_W-1 -: 2]};
		sq_trial = {root_q, 2'b01};
		sq_ge    = (sq_t >= sq_trial);
	end

	always_comb begin
		res.mean_price = MEAN_W'(mean_q);
		res.std_dev    = STD_W'(root_q);
		res.upper_band = BAND_W'(mean_q) + BAND_W'({root_q, 1'b0});
		res.lower_band = BAND_W'(mean_q) - BAND_W'({root_q, 1'b0});
		res.valid_res  = ok_q;
		if (!ok_q) begin
			res = '0;
		end
	end

	// ring write on pop, ring read while summing
	always_ff @(posedge clk) begin
		if (job_pop) begin
			hist_q[j_slot] <= j_price;
		end
		rdata_q <= hist_q[addr_q];
	end

	always_ff @(posedge clk) begin
		x_s2  <= rdata_q;
		sq_s2 <= V_W'(rdata_q) * V_W'(rdata_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_s1   <= 1'b0;
			v_s2    <= 1'b0;
			n_q     <= '0;
			iss_q   <= '0;
			acc_q   <= '0;
			addr_q  <= '0;
			ok_q    <= 1'b0;
			s_q     <= '0;
			q_q     <= '0;
			nq_q    <= '0;
			ss_q    <= '0;
			nn_q    <= '0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
			var_q   <= '0;
			root_q  <= '0;
			srem_q  <= '0;
			mean_q  <= '0;
		end else begin
			rv_s1 <= (state_q == ST_SUM) && (iss_q != n_q);
			v_s2  <= rv_s1;
			case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						n_q    <= j_n;
						ok_q   <= j_ok;
						addr_q <= j_slot;
						iss_q  <= '0;
						acc_q  <= '0;
						s_q    <= '0;
						q_q    <= '0;
						mean_q <= '0;
						root_q <= '0;
						state_q <= j_ok ? ST_LOAD : ST_OUT;
					end
				end
				ST_LOAD: begin
					// wait here so the ring write lands before the first read
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (iss_q != n_q) begin
						iss_q  <= iss_q + 1'b1;
						addr_q <= (addr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : addr_q - 1'b1;
					end
					if (v_s2) begin
						s_q   <= s_q + S_W'(x_s2);
						q_q   <= q_q + Q_W'(sq_s2);
						acc_q <= acc_q + 1'b1;
					end
					if (acc_q == n_q) begin
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					nq_q  <= NQ_W'(n_q) * NQ_W'(q_q);
					ss_q  <= NQ_W'(s_q) * NQ_W'(s_q);
					nn_q  <= NN_W'(n_q) * NN_W'(n_q);
					dvd_q <= DV_W'(s_q);
					dvs_q <= NN_W'(n_q);
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= ST_DIVM;
				end
				ST_DIVM, ST_DIVV: begin
					if (cnt_q != C_W'(DV_W)) begin
						rem_q <= dv_ge ? NN_W'(dv_t - {1'b0, dvs_q}) : NN_W'(dv_t);
						quo_q <= {quo_q[DV_W-2:0], dv_ge};
						dvd_q <= {dvd_q[DV_W-2:0], 1'b0};
						cnt_q <= cnt_q + 1'b1;
					end else if (state_q == ST_DIVM) begin
						mean_q <= quo_q[PB-1:0];
						dvd_q  <= nq_q - ss_q;
						dvs_q  <= nn_q;
						rem_q  <= '0;
						cnt_q  <= '0;
						state_q <= ST_DIVV;
					end else begin
						var_q  <= quo_q[V_W-1:0];
						root_q <= '0;
						srem_q <= '0;
						cnt_q  <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q != C_W'(PB)) begin
						srem_q <= sq_ge ? sq_t - sq_trial : sq_t;
						root_q <= {root_q[PB-2:0], sq_ge};
						var_q  <= {var_q[V_W-3:0], 2'b00};
						cnt_q  <= cnt_q + 1'b1;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/moving_average_bollinger_bands.sv]
// Top level: Bollinger bands over a configurable moving window.
// Depends on mabb_pkg, mabb_fifo, mabb_front, mabb_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | push / full          | close_price, first_of_series
//  result   | pop / empty          | mean_price, std_dev, upper_band, lower_band, valid_res
//  config   | psel,penable,pwrite  | paddr, pwdata, prdata (window_length at 0x0)
//
// One item at a time in the back sequencer. An item with a full window holds the
// back end through the window sum, the one-bit-per-cycle divider run twice and the
// two-bit-per-cycle root; an item without a full window goes straight to output.
// Two-entry queues on both sides let input and result stall independently.
// Reset clears all control state; the price ring needs no clearing.
module moving_average_bollinger_bands import mabb_pkg::*; #(
	parameter int unsigned MAX_WINDOW = 64,
	parameter int unsigned PRICE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [IN_PRICE_W-1:0] close_price,
	input  logic                  first_of_series,
	output logic                  empty,
	input  logic                  pop,
	output logic [MEAN_W-1:0]     mean_price,
	output logic [STD_W-1:0]      std_dev,
	output logic [BAND_W-1:0]     upper_band,
	output logic signed [BAND_W-1:0] lower_band,
	output logic                  valid_res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	localparam int unsigned PTR_W = $clog2(MAX_WINDOW);
	localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int unsigned JOB_W = PRICE_BITS + PTR_W + CNT_W + 1;

	logic [JOB_W-1:0] job_in, job_out;
	logic             job_empty, job_pop, in_take, cfg_we;
	logic [WIN_W-1:0] win;
	res_t             res_in, res_out;
	logic             res_full, res_push;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && (paddr[2] == 1'(REG_WINDOW));
	assign prdata  = (paddr[2] == 1'(REG_WINDOW)) ? 32'(win) : '0;
	assign in_take = push && !full;

	mabb_front #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_front (
		.clk, .arst_n,
		.cfg_we, .cfg_data(pwdata[WIN_W-1:0]), .window_length(win),
		.in_take, .close_price, .first_of_series, .job(job_in)
	);

	mabb_fifo #(.W(JOB_W), .DEPTH(2)) u_jobq (
		.clk, .arst_n,
		.wr_en(in_take), .wr_data(job_in), .full,
		.rd_en(job_pop), .rd_data(job_out), .empty(job_empty)
	);

	mabb_back #(.MAX_WINDOW(MAX_WINDOW), .PRICE_BITS(PRICE_BITS)) u_back (
		.clk, .arst_n,
		.job(job_out), .job_empty, .job_pop,
		.res(res_in), .res_full, .res_push
	);

	mabb_fifo #(.W($bits(res_t)), .DEPTH(2)) u_resq (
		.clk, .arst_n,
		.wr_en(res_push), .wr_data(res_in), .full(res_full),
		.rd_en(pop), .rd_data(res_out), .empty
	);

	assign mean_price = res_out.mean_price;
	assign std_dev    = res_out.std_dev;
	assign upper_band = res_out.upper_band;
	assign lower_band = res_out.lower_band;
	assign valid_res  = res_out.valid_res;

endmodule

[rtl/core/mabb_chk.sv]
// Port-level checker for the Bollinger band block, bound to the top level.
// Depends on mabb_pkg.
module mabb_chk import mabb_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  empty,
	input logic                  pop,
	input logic [MEAN_W-1:0]     mean_price,
	input logic [STD_W-1:0]      std_dev,
	input logic [BAND_W-1:0]     upper_band,
	input logic [BAND_W-1:0]     lower_band,
	input logic                  valid_res,
	input logic                  pready
);
	a_no_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !valid_res) |-> (mean_price == '0 && std_dev == '0 &&
			upper_band == '0 && lower_band == '0))
		else $error("result without full window carries nonzero values");

	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (upper_band == BAND_W'(BAND_W'(mean_price) + BAND_W'({std_dev, 1'b0}))))
		else $error("upper band does not match mean plus two deviations");

	a_lower: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (lower_band == BAND_W'(BAND_W'(mean_price) - BAND_W'({std_dev, 1'b0}))))
		else $error("lower band does not match mean minus two deviations");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(mean_price) && $stable(std_dev)
			&& $stable(valid_res)))
		else $error("waiting result changed before pop");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port not ready");

endmodule

bind moving_average_bollinger_bands mabb_chk u_mabb_chk (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for moving_average_bollinger_bands: table-driven directed
// requests, then random series and windows, checked against an in-bench predictor.
// Depends on mabb_pkg and the block's RTL.
module testbench;
	import mabb_pkg::*;

	localparam int unsigned RING = 64;
	localparam int unsigned RAND_ITEMS = 320;

	typedef struct {
		logic [IN_PRICE_W-1:0] price;
		logic                  restart;
		logic                  known;
		res_t                  res;
	} row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [IN_PRICE_W-1:0] close_price;
	logic                  first_of_series;
	logic                  empty;
	logic                  pop;
	logic [MEAN_W-1:0]     mean_price;
	logic [STD_W-1:0]      std_dev;
	logic [BAND_W-1:0]     upper_band;
	logic signed [BAND_W-1:0] lower_band;
	logic                  valid_res;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor state
	logic [IN_PRICE_W-1:0] ring_prices [RING];
	int unsigned           series_len;
	int unsigned           ring_wr;
	logic [WIN_W-1:0]      win_reg;

	res_t expected_bands [$];
	int   error_count;
	bit   stim_done;

	moving_average_bollinger_bands u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic res_t predict_bands(input logic [IN_PRICE_W-1:0] price,
			input logic restart);
		res_t r;
		int unsigned n;
		logic [63:0] s, q, x, var_v, sd, m;
		r = '0;
		if (restart) begin
			series_len = 0;
			ring_wr = 0;
		end
		ring_prices[ring_wr] = price;
		ring_wr = (ring_wr + 1) % RING;
		if (series_len < RING) series_len++;
		n = win_reg;
		if (n == 0) n = 1;
		if (n > RING) n = RING;
		if (series_len >= n) begin
			s = 0;
			q = 0;
			for (int k = 0; k < n; k++) begin
				x = ring_prices[(ring_wr + RING - 1 - k) % RING];
				s += x;
				q += x * x;
			end
			m = s / n;
			var_v = (n * q - s * s) / (n * n);
			sd = isqrt(var_v);
			r.mean_price = m[MEAN_W-1:0];
			r.std_dev    = sd[STD_W-1:0];
			r.upper_band = BAND_W'(m + 2 * sd);
			r.lower_band = BAND_W'(m - 2 * sd);
			r.valid_res  = 1'b1;
		end
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	task automatic idle_cycles(input int unsigned n);
		repeat (n) @(posedge clk);
	endtask

	task automatic write_window(input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= 3'(REG_WINDOW * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		win_reg = value[WIN_W-1:0];
	endtask

	// drain: drop push, wait for every expected result, then let the back end settle
	task automatic drain;
		push <= 1'b0;
		while (expected_bands.size() != 0) @(posedge clk);
		idle_cycles(400);
	endtask

	task automatic send_request(input logic [IN_PRICE_W-1:0] price, input logic restart,
			input logic known, input res_t want);
		res_t p;
		int   gap;
		gap = $urandom_range(0, 7) * $urandom_range(0, 1);
		if (gap != 0) begin
			push <= 1'b0;
			idle_cycles(gap);
		end
		push            <= 1'b1;
		close_price     <= price;
		first_of_series <= restart;
		@(posedge clk);
		while (full) @(posedge clk);
		p = predict_bands(price, restart);
		if (known && p != want) begin
			report("table mean", 64'(p.mean_price), 64'(want.mean_price));
		end
		expected_bands = {expected_bands, p};
	endtask

	// result side
	initial begin
		res_t want;
		int   gap;
		pop = 1'b0;
		gap = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_bands.size() == 0) begin
					report("unexpected result", 64'(mean_price), 64'(0));
				end else begin
					want = expected_bands.pop_front();
					if (mean_price !== want.mean_price)
						report("mean_price", 64'(mean_price), 64'(want.mean_price));
					if (std_dev !== want.std_dev)
						report("std_dev", 64'(std_dev), 64'(want.std_dev));
					if (upper_band !== want.upper_band)
						report("upper_band", 64'(upper_band), 64'(want.upper_band));
					if (lower_band !== want.lower_band)
						report("lower_band", 64'(lower_band), 64'(want.lower_band));
					if (valid_res !== want.valid_res)
						report("valid_res", 64'(valid_res), 64'(want.valid_res));
				end
				gap = stim_done ? 0 : $urandom_range(0, 7) * $urandom_range(0, 1);
			end
			if (gap > 0) begin
				gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		row_t table_rows [$];
		row_t row;
		res_t z;
		logic [IN_PRICE_W-1:0] base;
		push = 1'b0;
		close_price = '0;
		first_of_series = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		error_count = 0;
		stim_done = 1'b0;
		series_len = 0;
		ring_wr = 0;
		win_reg = WIN_RESET;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z = '0;
		// reset window 20: too few prices give all-zero results
		row = '{24'hFFFFFF, 1'b1, 1'b1, z};
		table_rows = {table_rows, row};
		for (int i = 0; i < 19; i++) begin
			row = '{IN_PRICE_W'(i * 997), 1'b0, i < 18, z};
			table_rows = {table_rows, row};
		end
		foreach (table_rows[i]) begin
			row = table_rows[i];
			send_request(row.price, row.restart, row.known, row.res);
		end
		drain();

		// window of one: std is zero, bands equal the price
		write_window(1);
		z = '{24'hFFFFFF, 23'd0, 25'hFFFFFF, 25'hFFFFFF, 1'b1};
		send_request(24'hFFFFFF, 1'b1, 1'b1, z);
		z = '{24'd0, 23'd0, 25'd0, 25'd0, 1'b1};
		send_request(24'd0, 1'b0, 1'b1, z);
		drain();
		// zero window acts as one
		write_window(0);
		send_request(24'h123456, 1'b0, 1'b1, '{24'h123456, 23'd0, 25'h123456, 25'h123456, 1'b1});
		drain();
		// oversize window saturates; alternating extremes give negative lower band
		write_window(127);
		for (int i = 0; i < 66; i++)
			send_request(i[0] ? 24'hFFFFFF : 24'd0, i == 0, 1'b0, z);
		drain();
		write_window(2);
		send_request(24'h000000, 1'b1, 1'b0, z);
		send_request(24'hFFFFFF, 1'b0, 1'b0, z);
		drain();

		// random phases: mostly short windows, occasionally large ones
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_window(64);
				1: write_window(1);
				default: write_window($urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
					: $urandom_range(1, 8));
			endcase
			base = IN_PRICE_W'($urandom);
			for (int i = 0; i < RAND_ITEMS / 8; i++) begin
				logic [IN_PRICE_W-1:0] p;
				p = ($urandom_range(0, 3) == 0) ? IN_PRICE_W'($urandom)
					: base + IN_PRICE_W'($urandom_range(0, 4095));
				send_request(p, $urandom_range(0, 40) == 0, 1'b0, z);
				if (ph == 3 && i == 20) begin
					push <= 1'b0;
					while (expected_bands.size() != 0) @(posedge clk);
				end
			end
			drain();
		end
		stim_done = 1'b1;
		drain();
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

[filelist.f]
rtl/core/mabb_pkg.sv
rtl/core/mabb_fifo.sv
rtl/core/mabb_front.sv
rtl/core/mabb_back.sv
rtl/core/moving_average_bollinger_bands.sv
rtl/core/mabb_chk.sv
tb/sv/testbench.sv
